FILE: hw/rtl/sic_pkg.sv
// sic_pkg: shared constants and opcodes of the sorted itemset containment core
// no dependencies; imported by the channel interfaces and every module but sic_ram

package sic_pkg;

	// beat field widths
	localparam int OPCODE_W = 3;
	localparam int ITEM_W   = 16;
	localparam int LABEL_W  = 8;
	localparam int PIDX_W   = 6;

	// default table sizes
	localparam int MAX_PATTERNS_DEF      = 64;
	localparam int MAX_PATTERN_ITEMS_DEF = 16;

	// input opcodes
	localparam logic [OPCODE_W-1:0] OP_CLEAR     = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_PAT_ITEM  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_PAT_END   = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_TRANS_ITEM = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_TRANS_END = 3'd4;

endpackage

FILE: hw/rtl/sic_in_if.sv
// sic_in_if: input channel, one command beat per handshake
// depends on sic_pkg for field widths

interface sic_in_if import sic_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [ITEM_W-1:0]   item_value;
	logic [LABEL_W-1:0]  class_label;

	modport source (output valid, output opcode, output item_value, output class_label,
		input ready);
	modport sink (input valid, input opcode, input item_value, input class_label,
		output ready);
endinterface

FILE: hw/rtl/sic_out_if.sv
// sic_out_if: result channel, one containment result per handshake
// depends on sic_pkg for field widths

interface sic_out_if import sic_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LABEL_W-1:0] out_label;
	logic [PIDX_W-1:0]  pattern_index;
	logic               matched;
	logic               last_result;
	logic               overflow;

	modport source (output valid, output out_label, output pattern_index, output matched,
		output last_result, output overflow, input ready);
	modport sink (input valid, input out_label, input pattern_index, input matched,
		input last_result, input overflow, output ready);
endinterface

FILE: hw/rtl/sic_ram.sv
// sic_ram: simple dual port memory, one write and one registered read per cycle
// no package dependency

module sic_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

FILE: hw/rtl/sic_cmp.sv
// sic_cmp: shared compare unit, advances one pattern tracker by one item
// depends on sic_pkg for the item width

module sic_cmp import sic_pkg::*; #(
	parameter int LW = 5
) (
	input  logic [ITEM_W-1:0] item,
	input  logic [ITEM_W-1:0] elem,
	input  logic [LW-1:0]     prog,
	input  logic              failed,
	input  logic [LW-1:0]     len,
	output logic [LW-1:0]     prog_nxt,
	output logic              failed_nxt,
	output logic              hit
);
	logic active;

	always_comb begin
		// complete or failed trackers ignore the item
		active     = !failed && (prog < len);
		prog_nxt   = prog;
		failed_nxt = failed;
		if (active) begin
			if (item == elem) begin
				prog_nxt = prog + LW'(1);
			end else if (item > elem) begin
				failed_nxt = 1'b1;
			end
		end
		hit = !failed_nxt && (prog_nxt == len);
	end
endmodule

FILE: hw/rtl/sorted_itemset_containment_core.sv
// sorted_itemset_containment_core: pattern table, per-pattern trackers and result walker
// depends on sic_pkg, sic_in_if, sic_out_if, sic_ram and sic_cmp
//
// usage
//   item channel: command beats (opcode, item_value, class_label). clear, pattern item,
//   pattern end and unused opcodes leave ready high. a transaction item sweeps the committed
//   patterns through the shared compare unit, one pattern per cycle, over the tracker
//   pipeline; ready is low during the sweep.
//   result channel: a transaction end walks the contained-pattern vector one index per
//   cycle unless a stalled receiver holds it, giving one beat per contained pattern in
//   ascending order (last_result on the final one), or a single unmatched beat.
//   results sit in an output register, so a new command beat is taken while the last
//   result still waits; a stalled receiver only halts the walk.
//   reset: pattern table empty, trackers clear, overflow flag low. the pattern memories are
//   not cleared: only entries of committed patterns are ever read, so no clearing pass.
//   tracker state lives in a memory with one valid bit per pattern; an invalid entry reads
//   as progress zero, not failed.

module sorted_itemset_containment_core import sic_pkg::*; #(
	parameter int MAX_PATTERNS      = MAX_PATTERNS_DEF,
	parameter int MAX_PATTERN_ITEMS = MAX_PATTERN_ITEMS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sic_in_if.sink    item,
	sic_out_if.source result
);
	localparam int MP    = MAX_PATTERNS;
	localparam int MPI   = MAX_PATTERN_ITEMS;
	localparam int IW    = (MP > 1) ? $clog2(MP) : 1;       // pattern index
	localparam int TW    = $clog2(MP + 1);                  // pattern count
	localparam int LW    = $clog2(MPI + 1);                 // pattern length / progress
	localparam int SD    = MP * MPI;
	localparam int AW    = (SD > 1) ? $clog2(SD) : 1;       // pattern store address
	localparam logic [AW-1:0] MPI_A = AW'(MPI);
	localparam logic [TW-1:0] MP_T  = TW'(MP);
	localparam logic [LW-1:0] MPI_L = LW'(MPI);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	// control state
	logic [1:0]    state_q;
	logic [TW-1:0] total_q;
	logic [LW-1:0] open_q;
	logic          ovf_q;
	logic [MP-1:0] trk_vld_q;   // tracker entry holds live progress
	logic [MP-1:0] empty_q;     // committed pattern has no items
	logic [MP-1:0] hit_q;       // pattern contained so far in this transaction
	logic [MP-1:0] rem_q;       // hits still to report
	logic          nomatch_q;
	logic [TW-1:0] k_q;
	logic [IW-1:0] e_q;

	// payload registers
	logic [ITEM_W-1:0]  item_q;
	logic [LABEL_W-1:0] lbl_q;

	// tracker pipeline
	logic          v_s1, v_s2;
	logic [IW-1:0] k_s1, k_s2;
	logic          vld_s1;
	logic [LW-1:0] p_s2, len_s2;
	logic          f_s2;

	// output register
	logic               out_vld_q;
	logic [LABEL_W-1:0] out_label_q;
	logic [PIDX_W-1:0]  out_idx_q;
	logic               out_match_q;
	logic               out_last_q;
	logic               out_ovf_q;

	logic accept, out_free, issue, scan_done;
	logic [MP-1:0] total_mask, hit_live, onehot_e, rem_nxt;
	logic cur_hit, emit_ld, emit_adv;

	// memory ports
	logic          st_we;
	logic [AW-1:0] st_waddr, st_raddr;
	logic [ITEM_W-1:0] st_rdata;
	logic          len_we;
	logic [LW-1:0] len_rdata;
	logic [LW:0]   trk_rdata, trk_wdata;
	logic [LW-1:0] p1;
	logic          f1;
	logic [LW-1:0] p_nxt;
	logic          f_nxt, hit_nxt;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign out_free   = !out_vld_q || result.ready;

	// patterns below the committed count
	always_comb begin
		for (int i = 0; i < MP; i++) begin
			total_mask[i] = (TW'(i) < total_q);
		end
	end
	assign hit_live = hit_q & total_mask;

	// transaction item sweep: read trackers and lengths for index k
	assign issue     = (state_q == ST_SCAN) && (k_q < total_q);
	assign scan_done = (state_q == ST_SCAN) && (k_q == total_q) && !v_s1 && !v_s2;

	// stage 1: tracker word, choose the current element of the pattern
	assign p1       = vld_s1 ? trk_rdata[LW-1:0] : '0;
	assign f1       = vld_s1 ? trk_rdata[LW] : 1'b0;
	assign st_raddr = AW'(AW'(k_s1) * MPI_A) + AW'(p1);

	// pattern item writes land at total * MPI + open length
	assign st_we    = accept && (item.opcode == OP_PAT_ITEM) && (total_q < MP_T)
		&& (open_q < MPI_L);
	assign st_waddr = AW'(AW'(total_q[IW-1:0]) * MPI_A) + AW'(open_q);
	assign len_we   = accept && (item.opcode == OP_PAT_END) && (total_q < MP_T);

	sic_ram #(.WIDTH(ITEM_W), .DEPTH(SD)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (item.item_value),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	sic_ram #(.WIDTH(LW), .DEPTH(MP)) u_len (
		.clk   (clk),
		.we    (len_we),
		.waddr (total_q[IW-1:0]),
		.wdata (open_q),
		.raddr (k_q[IW-1:0]),
		.rdata (len_rdata)
	);

	sic_ram #(.WIDTH(LW + 1), .DEPTH(MP)) u_trk (
		.clk   (clk),
		.we    (v_s2),
		.waddr (k_s2),
		.wdata (trk_wdata),
		.raddr (k_q[IW-1:0]),
		.rdata (trk_rdata)
	);

	// stage 2: compare against the stored element
	sic_cmp #(.LW(LW)) u_cmp (
		.item       (item_q),
		.elem       (st_rdata),
		.prog       (p_s2),
		.failed     (f_s2),
		.len        (len_s2),
		.prog_nxt   (p_nxt),
		.failed_nxt (f_nxt),
		.hit        (hit_nxt)
	);
	assign trk_wdata = {f_nxt, p_nxt};

	// result walker
	always_comb begin
		onehot_e = '0;
		onehot_e[e_q] = 1'b1;
	end
	assign cur_hit  = rem_q[e_q];
	assign rem_nxt  = rem_q & ~onehot_e;
	assign emit_ld  = (state_q == ST_EMIT) && out_free && (nomatch_q || cur_hit);
	assign emit_adv = (state_q == ST_EMIT) && !nomatch_q && (!cur_hit || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			total_q   <= '0;
			open_q    <= '0;
			ovf_q     <= 1'b0;
			trk_vld_q <= '0;
			empty_q   <= '0;
			hit_q     <= '0;
			rem_q     <= '0;
			nomatch_q <= 1'b0;
			k_q       <= '0;
			e_q       <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (issue) begin
				k_q <= k_q + TW'(1);
			end
			if (v_s2) begin
				trk_vld_q[k_s2] <= 1'b1;
				hit_q[k_s2]     <= hit_nxt;
			end
			if (scan_done) begin
				state_q <= ST_IDLE;
			end

			if (accept) begin
				case (item.opcode)
					OP_CLEAR: begin
						total_q   <= '0;
						open_q    <= '0;
						trk_vld_q <= '0;
					end
					OP_PAT_ITEM: begin
						if (st_we) begin
							open_q <= open_q + LW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					OP_PAT_END: begin
						if (len_we) begin
							empty_q[total_q[IW-1:0]]   <= (open_q == '0);
							hit_q[total_q[IW-1:0]]     <= (open_q == '0);
							trk_vld_q[total_q[IW-1:0]] <= 1'b0;
							total_q <= total_q + TW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						open_q <= '0;
					end
					OP_TRANS_ITEM: begin
						if (total_q != '0) begin
							state_q <= ST_SCAN;
							k_q     <= '0;
						end
					end
					OP_TRANS_END: begin
						// snapshot the hits, then trackers restart for the next transaction
						rem_q     <= hit_live;
						nomatch_q <= (hit_live == '0);
						e_q       <= '0;
						state_q   <= ST_EMIT;
						trk_vld_q <= '0;
						hit_q     <= empty_q;
					end
					default: begin
					end
				endcase
			end

			if (emit_adv) begin
				e_q <= e_q + IW'(1);
				if (cur_hit) begin
					rem_q <= rem_nxt;
					if (rem_nxt == '0) begin
						state_q <= ST_IDLE;
					end
				end
			end
			if (emit_ld && nomatch_q) begin
				nomatch_q <= 1'b0;
				state_q   <= ST_IDLE;
			end

			if (emit_ld) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && (item.opcode == OP_TRANS_ITEM)) begin
			item_q <= item.item_value;
		end
		if (accept && (item.opcode == OP_TRANS_END)) begin
			lbl_q <= item.class_label;
		end
		k_s1   <= k_q[IW-1:0];
		vld_s1 <= trk_vld_q[k_q[IW-1:0]];
		k_s2   <= k_s1;
		p_s2   <= p1;
		f_s2   <= f1;
		len_s2 <= len_rdata;
		if (emit_ld) begin
			out_label_q <= lbl_q;
			out_idx_q   <= nomatch_q ? '0 : PIDX_W'(e_q);
			out_match_q <= !nomatch_q;
			out_last_q  <= nomatch_q ? 1'b1 : (rem_nxt == '0);
			out_ovf_q   <= ovf_q;
		end
	end

	assign result.valid         = out_vld_q;
	assign result.out_label     = out_label_q;
	assign result.pattern_index = out_idx_q;
	assign result.matched       = out_match_q;
	assign result.last_result   = out_last_q;
	assign result.overflow      = out_ovf_q;

`ifndef ASSERT_OFF
	// tracker pipeline only runs inside a sweep
	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> (state_q == ST_SCAN))
		else $error("tracker pipeline active outside a sweep");

	// pattern count and open length stay within the table
	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q <= MP_T) && (open_q <= MPI_L))
		else $error("pattern count or open length beyond capacity");

	// the walker always has a hit left to report
	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && !nomatch_q) |-> (rem_q != '0))
		else $error("result walker running with nothing to report");

	// a result beat is only loaded over a free or draining output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit_ld |-> out_free)
		else $error("result overwritten while stalled");

	// the sweep visits each committed pattern once
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (k_q <= total_q))
		else $error("sweep index ran past the pattern count");
`endif
endmodule

FILE: tb/sorted_itemset_containment_checker.sv
`timescale 1ns / 1ps
// sorted_itemset_containment_checker: tracks pattern containment and checks the result beats
// depends on sic_pkg, sic_in_if and sic_out_if; watches both channels of the core

module sorted_itemset_containment_checker import sic_pkg::*; #(
	parameter int MAX_PATTERNS      = MAX_PATTERNS_DEF,
	parameter int MAX_PATTERN_ITEMS = MAX_PATTERN_ITEMS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	sic_in_if    item,
	sic_out_if   result,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic [PIDX_W-1:0]  index;
		logic               matched;
		logic               last;
		logic               overflow;
	} containment_t;

	// pattern table and per-pattern match trackers
	logic [ITEM_W-1:0] table_items [MAX_PATTERNS][MAX_PATTERN_ITEMS];
	int                table_len [MAX_PATTERNS];
	int                table_count;
	int                open_len;
	int                progress [MAX_PATTERNS];
	bit                dead [MAX_PATTERNS];
	bit                overflow_flag;
	containment_t      contained_q [$];

	task automatic clear_trackers();
		for (int k = 0; k < MAX_PATTERNS; k++) begin
			progress[k] = 0;
			dead[k]     = 1'b0;
		end
	endtask

	task automatic track_beat(input logic [OPCODE_W-1:0] op, input logic [ITEM_W-1:0] value,
		input logic [LABEL_W-1:0] label);
		int k;
		int last_hit;
		containment_t beat;
		case (op)
			OP_CLEAR: begin
				table_count = 0;
				open_len    = 0;
				clear_trackers();
			end
			OP_PAT_ITEM: begin
				if (table_count >= MAX_PATTERNS || open_len >= MAX_PATTERN_ITEMS) begin
					overflow_flag = 1'b1;
				end else begin
					table_items[table_count][open_len] = value;
					open_len++;
				end
			end
			OP_PAT_END: begin
				if (table_count >= MAX_PATTERNS) begin
					overflow_flag = 1'b1;
				end else begin
					table_len[table_count] = open_len;
					progress[table_count]  = 0;
					dead[table_count]      = 1'b0;
					table_count++;
				end
				open_len = 0;
			end
			OP_TRANS_ITEM: begin
				for (k = 0; k < table_count; k++)
					if (!dead[k] && progress[k] < table_len[k]) begin
						if (value == table_items[k][progress[k]])
							progress[k]++;
						else if (value > table_items[k][progress[k]])
							dead[k] = 1'b1;
					end
			end
			OP_TRANS_END: begin
				last_hit = -1;
				for (k = 0; k < table_count; k++)
					if (!dead[k] && progress[k] == table_len[k])
						last_hit = k;
				if (last_hit < 0) begin
					beat = '{label, {PIDX_W{1'b0}}, 1'b0, 1'b1, overflow_flag};
					contained_q.insert(contained_q.size(), beat);
				end else begin
					for (k = 0; k <= last_hit; k++)
						if (!dead[k] && progress[k] == table_len[k]) begin
							beat = '{label, PIDX_W'(k), 1'b1, k == last_hit, overflow_flag};
							contained_q.insert(contained_q.size(), beat);
						end
				end
				clear_trackers();
			end
			default: ;
		endcase
	endtask

	task automatic compare_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		containment_t want;
		if (!arst_n) begin
			table_count   = 0;
			open_len      = 0;
			overflow_flag = 1'b0;
			clear_trackers();
			contained_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (item.valid && item.ready)
				track_beat(item.opcode, item.item_value, item.class_label);
			if (result.valid && result.ready) begin
				if (contained_q.size() == 0) begin
					$error("result beat with nothing expected: label %0d index %0d matched %0d",
						result.out_label, result.pattern_index, result.matched);
					fail_count++;
				end else begin
					want = contained_q.pop_front();
					compare_field("out_label", want.label, result.out_label);
					compare_field("pattern_index", want.index, result.pattern_index);
					compare_field("matched", want.matched, result.matched);
					compare_field("last_result", want.last, result.last_result);
					compare_field("overflow", want.overflow, result.overflow);
				end
			end
			pending = contained_q.size();
		end
	end

endmodule

FILE: tb/sorted_itemset_containment_core_test.sv
`timescale 1ns / 1ps
// sorted_itemset_containment_core_test: drives pattern loads and transactions into the core
// depends on sic_pkg, sic_in_if, sic_out_if, the core and sorted_itemset_containment_checker

module sorted_itemset_containment_core_test import sic_pkg::*; ();

	localparam int MAX_PATTERNS      = MAX_PATTERNS_DEF;
	localparam int MAX_PATTERN_ITEMS = MAX_PATTERN_ITEMS_DEF;

	// opcodes the core must ignore
	localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

	// item values of one phase are drawn from a small sorted alphabet so that
	// transactions built from loaded patterns actually contain them
	localparam int ALPHABET_N   = 24;
	localparam int RANDOM_BEATS = 410;
	// longest sweep plus pipeline, with margin for the last result walk
	localparam int DRAIN_CYCLES = MAX_PATTERNS + 16;

	typedef logic [ALPHABET_N-1:0] item_set_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;

	sic_in_if  item_ch ();
	sic_out_if result_ch ();

	sorted_itemset_containment_core #(
		.MAX_PATTERNS      (MAX_PATTERNS),
		.MAX_PATTERN_ITEMS (MAX_PATTERN_ITEMS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	sorted_itemset_containment_checker #(
		.MAX_PATTERNS      (MAX_PATTERNS),
		.MAX_PATTERN_ITEMS (MAX_PATTERN_ITEMS)
	) containment_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// stimulus state
	logic [ITEM_W-1:0] alphabet [ALPHABET_N];
	item_set_t         pat_set [MAX_PATTERNS];
	int                pat_num;
	int                beats_sent;
	bit                tx_idle_on = 1'b1;
	bit                rx_idle_on = 1'b1;
	bit                table_filled;

	// one command beat; called and left at a falling edge, valid stays up when
	// the next beat follows without a gap
	task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [ITEM_W-1:0] value,
		input logic [LABEL_W-1:0] label);
		int gap;
		if ($urandom_range(0, 47) == 0)
			tx_idle_on = !tx_idle_on;
		gap = tx_idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.opcode      <= op;
		item_ch.item_value  <= value;
		item_ch.class_label <= label;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		if (op < OP_SPARE_FIRST)
			beats_sent++;
	endtask

	// n distinct alphabet positions
	function automatic item_set_t random_set(input int n);
		item_set_t s;
		s = '0;
		while ($countones(s) < n)
			s[$urandom_range(0, ALPHABET_N - 1)] = 1'b1;
		return s;
	endfunction

	// mostly short patterns, sometimes empty or full length, and once the run
	// is under way occasionally longer than a pattern may be
	function automatic int pick_size(input bit allow_long);
		int r;
		r = $urandom_range(0, 31);
		if (r == 0)
			return 0;
		if (r == 1)
			return MAX_PATTERN_ITEMS;
		if (r == 2 && allow_long)
			return MAX_PATTERN_ITEMS + $urandom_range(1, 2);
		return $urandom_range(1, 4);
	endfunction

	// wide alphabets spread over the whole item range, narrow ones crowd near zero
	task automatic new_alphabet(input bit wide);
		int v;
		v = wide ? $urandom_range(0, 1500) : $urandom_range(0, 3);
		for (int i = 0; i < ALPHABET_N; i++) begin
			alphabet[i] = ITEM_W'(v);
			v += wide ? $urandom_range(1, 2660) : $urandom_range(1, 2);
		end
	endtask

	// pattern items go out in ascending order, then the commit beat
	task automatic load_pattern(input item_set_t s);
		for (int i = 0; i < ALPHABET_N; i++)
			if (s[i])
				send_beat(OP_PAT_ITEM, alphabet[i], LABEL_W'($urandom));
		send_beat(OP_PAT_END, ITEM_W'($urandom), LABEL_W'($urandom));
		if (pat_num < MAX_PATTERNS) begin
			pat_set[pat_num] = s;
			pat_num++;
		end
	endtask

	task automatic run_transaction();
		int        shape;
		int        mid;
		item_set_t s;
		if ($urandom_range(0, 15) == 0)
			send_beat(OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
				ITEM_W'($urandom), LABEL_W'($urandom));
		shape = $urandom_range(0, 11);
		if (shape == 1) begin
			// noise: unordered, repeated, sometimes off-alphabet items
			repeat ($urandom_range(1, 8))
				send_beat(OP_TRANS_ITEM, $urandom_range(0, 1) ?
					alphabet[$urandom_range(0, ALPHABET_N - 1)] : ITEM_W'($urandom),
					LABEL_W'($urandom));
		end else if (shape != 0) begin
			// union of a few loaded patterns, maybe with extras or with one item knocked out
			s = '0;
			if (pat_num > 0)
				repeat ($urandom_range(1, 3))
					s |= pat_set[$urandom_range(0, pat_num - 1)];
			if ($urandom_range(0, 2) == 0)
				s |= random_set($urandom_range(1, 4));
			if ($urandom_range(0, 3) == 0)
				s[$urandom_range(0, ALPHABET_N - 1)] = 1'b0;
			mid = $urandom_range(0, ALPHABET_N - 1);
			for (int i = 0; i < ALPHABET_N; i++) begin
				// a pattern committed here only sees the rest of the transaction
				if (i == mid && $urandom_range(0, 7) == 0)
					load_pattern(random_set(pick_size(beats_sent > 150)));
				if (s[i]) begin
					send_beat(OP_TRANS_ITEM, alphabet[i], LABEL_W'($urandom));
					if ($urandom_range(0, 15) == 0)
						send_beat(OP_TRANS_ITEM, alphabet[i], LABEL_W'($urandom));
				end
			end
		end
		// shape zero ends an empty transaction
		send_beat(OP_TRANS_END, ITEM_W'($urandom), LABEL_W'($urandom));
	endtask

	// fill every table slot with empty or single-item patterns so that
	// transaction ends walk long result runs, then push past capacity
	task automatic fill_table();
		table_filled = 1'b1;
		repeat (MAX_PATTERNS + 2)
			load_pattern(random_set($urandom_range(0, 1)));
		repeat (3)
			run_transaction();
	endtask

	// result side: one stall draw per beat, long stretches without stalls
	initial begin
		int stall;
		result_ch.ready <= 1'b0;
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 47) == 0)
				rx_idle_on = !rx_idle_on;
			stall = rx_idle_on ? $urandom_range(0, 11) : 0;
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			@(negedge clk);
		end
	end

	initial begin
		item_ch.valid       <= 1'b0;
		item_ch.opcode      <= OP_CLEAR;
		item_ch.item_value  <= '0;
		item_ch.class_label <= '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table: a transaction end gives the single unmatched beat
		send_beat(OP_TRANS_END, 16'h0000, 8'h00);
		// pattern 0 spans both ends of the item range
		send_beat(OP_PAT_ITEM, 16'h0000, 8'h00);
		send_beat(OP_PAT_ITEM, 16'hFFFF, 8'h00);
		send_beat(OP_PAT_END, 16'h0000, 8'h00);
		// pattern 1 is empty and so contained in every transaction
		send_beat(OP_PAT_END, 16'h0000, 8'h00);
		// pattern 2 is {5, 9}
		send_beat(OP_PAT_ITEM, 16'd5, 8'h00);
		send_beat(OP_PAT_ITEM, 16'd9, 8'h00);
		send_beat(OP_PAT_END, 16'h0000, 8'h00);
		// all three contained, max label
		send_beat(OP_TRANS_ITEM, 16'h0000, 8'h00);
		send_beat(OP_TRANS_ITEM, 16'd5, 8'h00);
		send_beat(OP_TRANS_ITEM, 16'd9, 8'h00);
		send_beat(OP_TRANS_ITEM, 16'hFFFF, 8'h00);
		send_beat(OP_TRANS_END, 16'h0000, 8'hFF);
		// spare opcodes with every field bit set must change nothing
		send_beat(OP_SPARE_FIRST, 16'hFFFF, 8'hFF);
		send_beat(OP_SPARE_LAST, 16'hFFFF, 8'hFF);
		// pattern 3 = {9} committed mid-transaction; 5 fails pattern 0 as a larger item
		send_beat(OP_TRANS_ITEM, 16'd5, 8'h00);
		send_beat(OP_PAT_ITEM, 16'd9, 8'h00);
		send_beat(OP_PAT_END, 16'h0000, 8'h00);
		send_beat(OP_TRANS_ITEM, 16'd9, 8'h00);
		send_beat(OP_TRANS_END, 16'h0000, 8'h80);
		// descending items: 9 fails pattern 2 before its 5 arrives
		send_beat(OP_TRANS_ITEM, 16'd9, 8'h00);
		send_beat(OP_TRANS_ITEM, 16'd5, 8'h00);
		send_beat(OP_TRANS_END, 16'h0000, 8'h55);
		// clear empties the table again
		send_beat(OP_CLEAR, 16'hFFFF, 8'hFF);
		send_beat(OP_TRANS_END, 16'h0000, 8'h01);

		// random phases: clear, fresh alphabet, then a few patterns and several transactions or a table fill
		beats_sent = 0;
		while (beats_sent < RANDOM_BEATS) begin
			send_beat(OP_CLEAR, ITEM_W'($urandom), LABEL_W'($urandom));
			pat_num = 0;
			new_alphabet(1'($urandom_range(0, 1)));
			if (!table_filled && beats_sent > 200) begin
				fill_table();
			end else begin
				repeat ($urandom_range(1, 8))
					load_pattern(random_set(pick_size(beats_sent > 150)));
				repeat ($urandom_range(2, 6))
					run_transaction();
			end
		end
		if (!table_filled) begin
			send_beat(OP_CLEAR, ITEM_W'($urandom), LABEL_W'($urandom));
			pat_num = 0;
			fill_table();
		end
		item_ch.valid <= 1'b0;

		// let the last result walk finish, then watch for stray beats
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
